### rtl/track_label_majority_vote_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the track label vote core
// Immediate-style concurrent assertion wrappers, removable with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef TRACK_LABEL_MAJORITY_VOTE_CORE_ASSERT_SVH
`define TRACK_LABEL_MAJORITY_VOTE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TLMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLMV_ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define TLMV_ASSERT(label, prop, msg)
`define TLMV_ASSERT_NEXT(label, a, b, msg)
`endif
`endif

### rtl/tlmv_pkg.sv
// ---------------------------------------------------------------------------
// tlmv_pkg
// Shared constants and types of the track label vote core.
// ---------------------------------------------------------------------------
package tlmv_pkg;
    localparam int TRACK_SLOTS   = 16;
    localparam int HISTORY_DEPTH = 7;
    localparam int DIGIT_CLASSES = 16;
    localparam int TRACK_ID_BITS = 16;
    localparam int SLOT_BITS     = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int POS_BITS      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(HISTORY_DEPTH + 1);
    localparam int DIG_BITS      = 4;
    localparam int MISS_BITS     = 5;
    localparam logic [MISS_BITS-1:0] MISS_MAX = 5'd31;

    localparam logic FUNC_OBS = 1'b0;
    localparam logic FUNC_EOF = 1'b1;

    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [0:0] REG_MISS_LIMIT = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [CNT_BITS-1:0]  n;
        logic [POS_BITS-1:0]  wpos;
    } vote_cmd_t;

    typedef struct packed {
        logic                 done;
        logic                 color;
        logic [DIG_BITS-1:0]  digit;
    } vote_res_t;
endpackage

### rtl/tlmv_vote_unit.sv
// ---------------------------------------------------------------------------
// tlmv_vote_unit
// Walks one slot's window newest first, one entry a cycle, counting colours
// and digits, then scans the class histogram one class a cycle for the majority.
// ---------------------------------------------------------------------------
`include "track_label_majority_vote_core_assert.svh"
module tlmv_vote_unit
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  tlmv_pkg::vote_cmd_t                           cmd,
    input  logic [tlmv_pkg::HISTORY_DEPTH-1:0]            cwin,
    input  logic [tlmv_pkg::HISTORY_DEPTH*tlmv_pkg::DIG_BITS-1:0] dwin,
    output tlmv_pkg::vote_res_t                           res
);
    import tlmv_pkg::*;

    localparam logic [1:0] V_IDLE = 2'd0;
    localparam logic [1:0] V_WALK = 2'd1;
    localparam logic [1:0] V_SCAN = 2'd2;

    logic [1:0]          st_reg, st_next;
    logic [CNT_BITS-1:0] k_reg, k_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [CNT_BITS-1:0] red_reg, red_next, blue_reg, blue_next;
    logic [CNT_BITS-1:0] hist_reg [DIGIT_CLASSES];
    logic [DIG_BITS-1:0] cls_reg, cls_next;
    logic [DIG_BITS-1:0] best_reg, best_next;
    logic [CNT_BITS-1:0] bcnt_reg, bcnt_next;
    logic [POS_BITS-1:0] prev_pos;
    logic [DIG_BITS-1:0] cur_dig;
    logic                done_reg, done_next;

    always_comb
    begin
        prev_pos = (pos_reg == '0) ? POS_BITS'(HISTORY_DEPTH - 1) : pos_reg - 1'b1;
        cur_dig  = dwin[prev_pos*DIG_BITS +: DIG_BITS];
        st_next = st_reg; k_next = k_reg; pos_next = pos_reg;
        red_next = red_reg; blue_next = blue_reg; cls_next = cls_reg;
        best_next = best_reg; bcnt_next = bcnt_reg; done_next = 1'b0;
        unique case (st_reg)
            V_IDLE:
            begin
                if (cmd.start)
                begin
                    st_next = V_WALK; k_next = cmd.n; pos_next = cmd.wpos;
                    red_next = '0; blue_next = '0;
                end
            end
            V_WALK:
            begin
                if (k_reg == '0)
                begin
                    st_next = V_SCAN; cls_next = '0; best_next = '0; bcnt_next = '0;
                end
                else
                begin
                    k_next = k_reg - 1'b1; pos_next = prev_pos;
                    if (cwin[prev_pos]) blue_next = blue_reg + 1'b1;
                    else red_next = red_reg + 1'b1;
                end
            end
            V_SCAN:
            begin
                if (hist_reg[cls_reg] > bcnt_reg)
                begin
                    bcnt_next = hist_reg[cls_reg]; best_next = cls_reg;
                end
                cls_next = cls_reg + 1'b1;
                if (cls_reg == DIG_BITS'(DIGIT_CLASSES - 1))
                begin
                    st_next = V_IDLE; done_next = 1'b1;
                end
            end
            default: st_next = V_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= V_IDLE; done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next; pos_reg <= pos_next; red_reg <= red_next;
        blue_reg <= blue_next; cls_reg <= cls_next; best_reg <= best_next;
        bcnt_reg <= bcnt_next;
        for (int i = 0; i < DIGIT_CLASSES; i++)
        begin
            if (st_reg == V_IDLE && cmd.start)
                hist_reg[i] <= '0;
            else if (st_reg == V_WALK && k_reg != '0 && cur_dig == DIG_BITS'(i))
                hist_reg[i] <= hist_reg[i] + 1'b1;
        end
    end

    assign res.done  = done_reg;
    assign res.color = (red_reg > blue_reg) ? 1'b0 : 1'b1;
    assign res.digit = best_reg;

    `TLMV_ASSERT(a_done_after_scan, done_reg |-> $past(st_reg) == V_SCAN, "done without scan")
    `TLMV_ASSERT_NEXT(a_walk_count, st_reg == V_WALK && k_reg != '0,
        red_reg + blue_reg == $past(red_reg + blue_reg) + 1'b1, "vote count slip")
    `TLMV_ASSERT(a_no_start_busy, (st_reg != V_IDLE) |-> !cmd.start, "start while busy")
endmodule

### rtl/track_label_majority_vote_core.sv
// ---------------------------------------------------------------------------
// track_label_majority_vote_core
// Per-track sliding window vote on colour and digit class.
// ---------------------------------------------------------------------------
// Input beats on s_axis: tuser = func (0 observe, 1 end of frame),
// tdata = track, colour, digit class. Output beats on m_axis carry one
// result per observation: tdata = track, voted colour, voted digit,
// tuser = table_full. End-of-frame beats give no result.
// An observation searches the slot table one slot a cycle, then free slots
// one a cycle, passes a write state and a start state, walks the window one
// entry a cycle, scans the 16 digit classes one a cycle and registers the
// result before m_axis_tvalid rises. A dropped observation ends after the
// free slot search; an end of frame visits every slot once. The slot scan and
// the vote walker, shared by all slots, set the time per beat. One beat at a
// time is taken; the result waits in an output register and s_axis_tready
// stays low until it is taken, so a stalled receiver stalls the input.
// Reset empties the table and sets window_len 7, miss_limit 5.
// ---------------------------------------------------------------------------
`include "track_label_majority_vote_core_assert.svh"
module track_label_majority_vote_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // track, colour, digit class, pad
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // track, voted colour, voted digit, pad
    output logic        m_axis_tuser   // table_full
);
    import tlmv_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_VOTE  = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_EOF   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]  wlen_reg;
    logic [4:0]  mlim_reg;
    logic [2:0]  st_reg;
    logic [SLOT_BITS:0] idx_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [TRACK_ID_BITS-1:0] id_reg;
    logic        col_reg;
    logic [DIG_BITS-1:0] dig_reg;

    logic [TRACK_SLOTS-1:0] valid_reg, seen_reg;
    logic [TRACK_ID_BITS-1:0] track_reg [TRACK_SLOTS];
    logic [HISTORY_DEPTH-1:0] cwin_reg [TRACK_SLOTS];
    logic [HISTORY_DEPTH*DIG_BITS-1:0] dwin_reg [TRACK_SLOTS];
    logic [CNT_BITS-1:0] fill_reg [TRACK_SLOTS];
    logic [POS_BITS-1:0] wpos_reg [TRACK_SLOTS];
    logic [MISS_BITS-1:0] miss_reg [TRACK_SLOTS];

    logic        ovalid_reg;
    logic [15:0] otrack_reg;
    logic        ocol_reg, ofull_reg;
    logic [DIG_BITS-1:0] odig_reg;

    logic [SLOT_BITS-1:0] si;
    logic [CNT_BITS-1:0] eff_win, fill_cur, fill_new;
    logic [POS_BITS-1:0] pos_cur, pos_new;
    logic [MISS_BITS-1:0] miss_inc;
    logic [DIG_BITS-1:0] dig_sat;
    vote_cmd_t vcmd;
    vote_res_t vres;

    assign si = idx_reg[SLOT_BITS-1:0];
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MISS_LIMIT) ? {27'd0, mlim_reg} : {29'd0, wlen_reg};
    assign s_axis_tready = (st_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {3'd0, odig_reg, ocol_reg, otrack_reg};
    assign m_axis_tuser = ofull_reg;

    assign eff_win = (wlen_reg == 3'd0) ? CNT_BITS'(1) :
                     (32'(wlen_reg) > HISTORY_DEPTH) ? CNT_BITS'(HISTORY_DEPTH) :
                     CNT_BITS'(wlen_reg);
    assign fill_cur = fill_reg[slot_reg];
    assign fill_new = (fill_cur < eff_win) ? fill_cur + 1'b1 : eff_win;
    assign pos_cur  = wpos_reg[slot_reg];
    assign pos_new  = (32'(pos_cur) >= HISTORY_DEPTH - 1) ? '0 : pos_cur + 1'b1;
    assign miss_inc = (miss_reg[si] < MISS_MAX) ? miss_reg[si] + 1'b1 : miss_reg[si];
    assign dig_sat  = (32'(s_axis_tdata[20:17]) >= DIGIT_CLASSES) ?
                      DIG_BITS'(DIGIT_CLASSES - 1) : s_axis_tdata[20:17];

    assign vcmd.start = (st_reg == S_VOTE);
    assign vcmd.n     = fill_cur;
    assign vcmd.wpos  = pos_cur;

    tlmv_vote_unit u_vote
    (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (vcmd),
        .cwin (cwin_reg[slot_reg]),
        .dwin (dwin_reg[slot_reg]),
        .res  (vres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= 3'd7; mlim_reg <= 5'd5; st_reg <= S_IDLE; idx_reg <= '0;
            valid_reg <= '0; seen_reg <= '0; ovalid_reg <= 1'b0;
            for (int i = 0; i < TRACK_SLOTS; i++)
            begin
                fill_reg[i] <= '0; wpos_reg[i] <= '0; miss_reg[i] <= '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    REG_WINDOW_LEN: wlen_reg <= pwdata[2:0];
                    REG_MISS_LIMIT: mlim_reg <= pwdata[4:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && m_axis_tready) ovalid_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        id_reg <= s_axis_tdata[15:0]; col_reg <= s_axis_tdata[16];
                        dig_reg <= dig_sat; idx_reg <= '0;
                        st_reg <= (s_axis_tuser == FUNC_EOF) ? S_EOF : S_FIND;
                    end
                end
                S_FIND:
                begin
                    if (idx_reg == (SLOT_BITS+1)'(TRACK_SLOTS))
                    begin
                        idx_reg <= '0; st_reg <= S_FREE;
                    end
                    else if (valid_reg[si] && track_reg[si] == id_reg)
                    begin
                        slot_reg <= si; st_reg <= S_WRITE;
                    end
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_FREE:
                begin
                    if (idx_reg == (SLOT_BITS+1)'(TRACK_SLOTS))
                    begin
                        otrack_reg <= id_reg; ocol_reg <= 1'b0; odig_reg <= '0;
                        ofull_reg <= 1'b1; ovalid_reg <= 1'b1; st_reg <= S_IDLE;
                    end
                    else if (!valid_reg[si])
                    begin
                        slot_reg <= si; valid_reg[si] <= 1'b1; track_reg[si] <= id_reg;
                        fill_reg[si] <= '0; wpos_reg[si] <= '0; miss_reg[si] <= '0;
                        st_reg <= S_WRITE;
                    end
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_WRITE:
                begin
                    cwin_reg[slot_reg][pos_cur] <= col_reg;
                    dwin_reg[slot_reg][pos_cur*DIG_BITS +: DIG_BITS] <= dig_reg;
                    wpos_reg[slot_reg] <= pos_new; fill_reg[slot_reg] <= fill_new;
                    miss_reg[slot_reg] <= '0; seen_reg[slot_reg] <= 1'b1;
                    st_reg <= S_VOTE;
                end
                S_VOTE: st_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (vres.done)
                    begin
                        otrack_reg <= id_reg; ocol_reg <= vres.color;
                        odig_reg <= vres.digit; ofull_reg <= 1'b0; st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1; st_reg <= S_IDLE;
                end
                S_EOF:
                begin
                    if (valid_reg[si] && !seen_reg[si])
                    begin
                        miss_reg[si] <= (miss_inc >= mlim_reg) ? '0 : miss_inc;
                        if (miss_inc >= mlim_reg)
                        begin
                            valid_reg[si] <= 1'b0; fill_reg[si] <= '0;
                            wpos_reg[si] <= '0;
                        end
                    end
                    seen_reg[si] <= 1'b0;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SLOT_BITS+1)'(TRACK_SLOTS - 1)) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    `TLMV_ASSERT(a_ready_idle, s_axis_tready |-> st_reg == S_IDLE && !ovalid_reg, "ready busy")
    `TLMV_ASSERT_NEXT(a_hold_out, ovalid_reg && !m_axis_tready,
        ovalid_reg && $stable(m_axis_tdata), "output beat dropped")
    `TLMV_ASSERT(a_full_clean, (ovalid_reg && ofull_reg) |-> (odig_reg == '0 && !ocol_reg),
        "dropped beat carries labels")
endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the track label vote core. Observation and
// end-of-frame beats go in on s_axis with random gaps; m_axis is stalled at
// random. Each result is compared with the label vote worked out here, over
// several window and miss-limit settings written on APB between phases.
// ---------------------------------------------------------------------------
module tb;
    import tlmv_pkg::*;

    typedef struct packed {
        logic [15:0] trk;
        logic        col;
        logic [3:0]  dig;
        logic        full;
    } label_t;

    typedef struct {
        logic        func;
        logic [15:0] trk;
        logic        col;
        logic [3:0]  dig;
        logic        chk;
        label_t      want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    // predictor state
    logic [2:0]  win_len;
    logic [4:0]  miss_lim;
    logic        sl_valid [TRACK_SLOTS];
    logic [15:0] sl_track [TRACK_SLOTS];
    logic        sl_col   [TRACK_SLOTS][HISTORY_DEPTH];
    logic [3:0]  sl_dig   [TRACK_SLOTS][HISTORY_DEPTH];
    int          sl_fill  [TRACK_SLOTS];
    int          sl_wr    [TRACK_SLOTS];
    logic [4:0]  sl_miss  [TRACK_SLOTS];
    logic        sl_seen  [TRACK_SLOTS];

    label_t labels_due[$];
    row_t   rows[$];
    int     errors = 0;
    int     stall_left = 0;

    track_label_majority_vote_core dut (.*);

    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("tb: errors");
        $finish;
    end

    function automatic void drop_slot(int s);
        sl_valid[s] = 1'b0;
        sl_fill[s] = 0;
        sl_wr[s] = 0;
        sl_miss[s] = '0;
        sl_seen[s] = 1'b0;
    endfunction

    function automatic void clear_table();
        for (int s = 0; s < TRACK_SLOTS; s++)
        begin
            drop_slot(s);
            sl_track[s] = '0;
        end
    endfunction

    function automatic void add_row(logic func, logic [15:0] trk, logic col,
                                    logic [3:0] dig, logic chk, label_t want);
        row_t rw;
        rw.func = func;
        rw.trk = trk;
        rw.col = col;
        rw.dig = dig;
        rw.chk = chk;
        rw.want = want;
        rows.insert(rows.size(), rw);
    endfunction

    // returns 1 when the beat yields a result
    function automatic bit vote_labels(logic func, logic [15:0] trk, logic col,
                                       logic [3:0] dig, output label_t r);
        int found, w, p, red, blue, best, best_n;
        int cnt[DIGIT_CLASSES];
        found = -1;
        r = '0;
        if (func == FUNC_EOF)
        begin
            for (int s = 0; s < TRACK_SLOTS; s++)
            begin
                if (sl_valid[s] && !sl_seen[s])
                begin
                    if (sl_miss[s] < MISS_MAX) sl_miss[s]++;
                    if (sl_miss[s] >= miss_lim) drop_slot(s);
                end
                sl_seen[s] = 1'b0;
            end
            return 1'b0;
        end
        for (int s = 0; s < TRACK_SLOTS; s++)
            if (found < 0 && sl_valid[s] && sl_track[s] == trk) found = s;
        if (found < 0)
        begin
            for (int s = 0; s < TRACK_SLOTS; s++)
                if (found < 0 && !sl_valid[s]) found = s;
            if (found < 0)
            begin
                r.trk = trk;
                r.full = 1'b1;
                return 1'b1;
            end
            drop_slot(found);
            sl_valid[found] = 1'b1;
            sl_track[found] = trk;
        end
        p = sl_wr[found];
        sl_col[found][p] = col;
        sl_dig[found][p] = dig;
        sl_wr[found] = (p + 1) % HISTORY_DEPTH;
        w = (win_len == 0) ? 1 : win_len;
        if (sl_fill[found] < w) sl_fill[found]++;
        if (sl_fill[found] > w) sl_fill[found] = w;
        sl_miss[found] = '0;
        sl_seen[found] = 1'b1;
        red = 0;
        blue = 0;
        foreach (cnt[k]) cnt[k] = 0;
        p = sl_wr[found];
        for (int k = 0; k < sl_fill[found]; k++)
        begin
            p = (p + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
            if (sl_col[found][p]) blue++; else red++;
            cnt[sl_dig[found][p]]++;
        end
        best = 0;
        best_n = 0;
        for (int k = 0; k < DIGIT_CLASSES; k++)
            if (cnt[k] > best_n)
            begin
                best_n = cnt[k];
                best = k;
            end
        r.trk = trk;
        r.col = (red > blue) ? 1'b0 : 1'b1;
        r.dig = best[3:0];
        return 1'b1;
    endfunction

    task automatic reg_write(logic [0:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_WINDOW_LEN) win_len = v[2:0];
        else miss_lim = v[4:0];
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (labels_due.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 30) return;
        s_axis_tvalid <= 1'b0;
        if (g < 92) repeat ($urandom_range(1, 3)) @(negedge clk);
        else repeat ($urandom_range(10, 60)) @(negedge clk);
    endtask

    task automatic send_beat(logic func, logic [15:0] trk, logic col, logic [3:0] dig,
                             bit chk, label_t want);
        label_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {3'b000, dig, col, trk};
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        if (vote_labels(func, trk, col, dig, r))
        begin
            if (chk && r !== want)
            begin
                errors++;
                $display("%0t table row mismatch: expected %h predicted %h",
                         $time, want, r);
            end
            labels_due.insert(labels_due.size(), chk ? want : r);
        end
        @(negedge clk);
        idle_gap();
    endtask

    // receiver
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            stall_left = $urandom_range(10, 60);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        label_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[20:17], m_axis_tuser};
            if (labels_due.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: expected none actual %h", $time, got);
            end
            else
            begin
                want = labels_due[0];
                labels_due.delete(0);
                if (got.trk !== want.trk || got.col !== want.col || got.dig !== want.dig
                    || got.full !== want.full)
                begin
                    errors++;
                    $display("%0t mismatch: expected trk %h col %b dig %h full %b",
                             $time, want.trk, want.col, want.dig, want.full);
                    $display("%0t           actual   trk %h col %b dig %h full %b",
                             $time, got.trk, got.col, got.dig, got.full);
                end
            end
        end
    end

    task automatic random_phase(int n);
        logic [15:0] pool[8];
        logic [15:0] id;
        foreach (pool[i]) pool[i] = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_beat(FUNC_EOF, 16'($urandom), 1'($urandom), 4'($urandom), 1'b0, '0);
            else
            begin
                if ($urandom_range(0, 9) < 7) id = pool[$urandom_range(0, 7)];
                else if ($urandom_range(0, 1)) id = 16'($urandom_range(0, 23));
                else id = 16'($urandom);
                send_beat(FUNC_OBS, id, $urandom_range(0, 9) < 4,
                          4'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3)),
                          1'b0, '0);
            end
        end
    endtask

    initial
    begin
        row_t rw;
        clear_table();
        win_len = 3'd7;
        miss_lim = 5'd5;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed rows: extremes, ties, window, full table
        add_row(FUNC_OBS, 16'hFFFF, 1'b0, 4'hF, 1'b1, label_t'{16'hFFFF, 1'b0, 4'hF, 1'b0});
        add_row(FUNC_OBS, 16'h0000, 1'b1, 4'h0, 1'b1, label_t'{16'h0000, 1'b1, 4'h0, 1'b0});
        add_row(FUNC_OBS, 16'hFFFF, 1'b1, 4'h3, 1'b1, label_t'{16'hFFFF, 1'b1, 4'h3, 1'b0});
        add_row(FUNC_OBS, 16'hFFFF, 1'b0, 4'h3, 1'b0, '0);
        add_row(FUNC_OBS, 16'hFFFF, 1'b1, 4'hF, 1'b0, '0);
        add_row(FUNC_EOF, 16'hAAAA, 1'b1, 4'hF, 1'b0, '0);
        add_row(FUNC_EOF, 16'h5555, 1'b0, 4'h0, 1'b0, '0);
        add_row(FUNC_OBS, 16'h0000, 1'b0, 4'h8, 1'b0, '0);
        for (int i = 2; i < 16; i++)
            add_row(FUNC_OBS, 16'(i * 4097), i[0], i[3:0], 1'b0, '0);
        add_row(FUNC_OBS, 16'h1234, 1'b1, 4'h1, 1'b1, label_t'{16'h1234, 1'b0, 4'h0, 1'b1});
        foreach (rows[i])
        begin
            rw = rows[i];
            send_beat(rw.func, rw.trk, rw.col, rw.dig, rw.chk, rw.want);
        end
        random_phase(40);
        wait_idle();

        reg_write(REG_WINDOW_LEN, 32'd1);
        reg_write(REG_MISS_LIMIT, 32'd1);
        random_phase(300);
        wait_idle();
        reg_write(REG_WINDOW_LEN, 32'd0);
        reg_write(REG_MISS_LIMIT, 32'd0);
        random_phase(250);
        wait_idle();
        reg_write(REG_WINDOW_LEN, 32'd4);
        reg_write(REG_MISS_LIMIT, 32'd31);
        random_phase(300);
        wait_idle();
        reg_write(REG_WINDOW_LEN, 32'hFFFF_FFFF);
        reg_write(REG_MISS_LIMIT, 32'd2);
        random_phase(300);
        wait_idle();
        reg_write(REG_WINDOW_LEN, 32'd3);
        reg_write(REG_MISS_LIMIT, 32'd5);
        random_phase(230);

        wait_idle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
